// ===== design/stp_pkg.sv =====
// Package for the slot table positioner: beat types, mode codes, reset constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package stp_pkg;

	localparam int SpacingW = 20;
	localparam int CountW   = 3;
	localparam int TargetW  = 23;
	localparam int ModeW    = 3;
	localparam int SlotW    = 2;
	localparam int PosW     = 32;
	localparam int CfgIdxW  = 2;

	localparam logic [SpacingW-1:0] SPACING_RST = SpacingW'(20000);
	localparam logic [CountW-1:0]   COUNT_RST   = CountW'(3);
	localparam logic [TargetW-1:0]  TARGET_RST  = TargetW'(20000);

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_SLOT_SPACING = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SLOT_COUNT   = 2'd1;

	// mode codes
	localparam logic [ModeW-1:0] MODE_START  = 3'd0;
	localparam logic [ModeW-1:0] MODE_HOMING = 3'd1;
	localparam logic [ModeW-1:0] MODE_MANUAL = 3'd2;
	localparam logic [ModeW-1:0] MODE_AUTO   = 3'd3;
	localparam logic [ModeW-1:0] MODE_MOVING = 3'd4;

	localparam logic DIR_RED  = 1'b0;
	localparam logic DIR_GRAY = 1'b1;

	typedef struct packed {
		logic                   move_held;
		logic                   direction_press;
		logic                   go_press;
		logic                   mode_press;
		logic                   red_stop_clear;
		logic                   gray_stop_clear;
		logic signed [PosW-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic             motor_on;
		logic             motor_dir;
		logic             zero_position;
		logic [ModeW-1:0] mode_now;
		logic [SlotW-1:0] slot_now;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/stp_mode_ctrl.sv =====
// Mode controller: mode, slot, target, run and direction registers plus next-state logic.
// Depends on stp_pkg.
`default_nettype none

module stp_mode_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire stp_pkg::in_item_t              item,
	input  wire logic [stp_pkg::SpacingW-1:0]   slot_spacing,
	input  wire logic [stp_pkg::CountW-1:0]     slot_count,
	output stp_pkg::out_item_t                  res
);
	import stp_pkg::*;

	logic [ModeW-1:0]   mode_q, mode_d;
	logic [SlotW-1:0]   slot_q, slot_d;
	logic [TargetW-1:0] target_q, target_d;
	logic               run_q, run_d;
	logic               dir_q, dir_d;
	logic               zero_d;

	logic [CountW-1:0]  slot_inc;
	logic [SlotW-1:0]   slot_sel;
	logic [CountW-1:0]  slot_mul;
	logic [TargetW-1:0] target_prod;
	logic               ahead_clear;
	logic signed [PosW:0] pos_x;
	logic signed [PosW:0] tgt_go_x;
	logic signed [PosW:0] tgt_q_x;

	assign slot_inc    = {1'b0, slot_q} + 3'd1;
	// slot after a press in auto mode, wrapping at slot_count or past the 2-bit range
	assign slot_sel    = !item.direction_press ? slot_q :
		((slot_inc >= slot_count || slot_inc > 3'd3) ? '0 : slot_inc[SlotW-1:0]);
	assign slot_mul    = {1'b0, slot_sel} + 3'd1;
	assign target_prod = {20'b0, slot_mul} * {3'b0, slot_spacing};
	assign ahead_clear = (dir_q == DIR_GRAY) ? item.gray_stop_clear : item.red_stop_clear;
	// 33-bit signed compare of unsigned target against signed position
	assign pos_x    = {item.position[PosW-1], item.position};
	assign tgt_go_x = $signed({{(PosW+1-TargetW){1'b0}}, target_prod});
	assign tgt_q_x  = $signed({{(PosW+1-TargetW){1'b0}}, target_q});

	always_comb begin
		mode_d   = mode_q;
		slot_d   = slot_q;
		target_d = target_q;
		run_d    = run_q;
		dir_d    = dir_q;
		zero_d   = 1'b0;
		case (mode_q)
			MODE_HOMING: begin
				if (!item.red_stop_clear) begin
					run_d  = 1'b0;
					zero_d = 1'b1;
					mode_d = MODE_MANUAL;
				end
			end
			MODE_MANUAL: begin
				run_d = ahead_clear & item.move_held;
				if (item.direction_press)
					dir_d = ~dir_q;
				if (item.mode_press)
					mode_d = MODE_AUTO;
			end
			MODE_AUTO: begin
				slot_d = slot_sel;
				if (item.go_press) begin
					target_d = target_prod;
					dir_d    = (tgt_go_x > pos_x) ? DIR_GRAY : DIR_RED;
					run_d    = 1'b1;
					mode_d   = MODE_MOVING;
				end
				// mode press wins over go
				if (item.mode_press)
					mode_d = MODE_MANUAL;
			end
			MODE_MOVING: begin
				if ((dir_q == DIR_GRAY) ? (pos_x >= tgt_q_x) : (pos_x <= tgt_q_x)) begin
					run_d  = 1'b0;
					mode_d = MODE_AUTO;
				end
			end
			default: begin
				if (item.red_stop_clear) begin
					dir_d = DIR_RED;
					run_d = 1'b1;
				end
				mode_d = MODE_HOMING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			slot_q   <= '0;
			target_q <= TARGET_RST;
			run_q    <= 1'b0;
			dir_q    <= DIR_RED;
		end else if (fire) begin
			mode_q   <= mode_d;
			slot_q   <= slot_d;
			target_q <= target_d;
			run_q    <= run_d;
			dir_q    <= dir_d;
		end
	end

	assign res.motor_on      = run_d;
	assign res.motor_dir     = dir_d;
	assign res.zero_position = zero_d;
	assign res.mode_now      = mode_d;
	assign res.slot_now      = slot_d;

endmodule

`default_nettype wire

// ===== design/stp_out_buf.sv =====
// Result register: holds one result beat until the consumer takes it.
// Depends on stp_pkg.
`default_nettype none

module stp_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire stp_pkg::out_item_t res,
	output logic                    room,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output stp_pkg::out_item_t      out_item
);
	import stp_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	// a held beat leaving this cycle frees the register for the next one
	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			item_q <= res;
	end

endmodule

`default_nettype wire

// ===== design/slot_table_positioner_core.sv =====
// Slot table positioner: one control tick per input beat, one result beat per tick.
// Each beat passes an input register, the mode update logic and a result register,
// and a new beat is taken every cycle unless the result register is full and not
// being drained. Configuration writes are always ready.
// Depends on stp_pkg, stp_mode_ctrl and stp_out_buf.
`default_nettype none

module slot_table_positioner_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire stp_pkg::in_item_t            in_item,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output stp_pkg::out_item_t                out_item,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [stp_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [stp_pkg::SpacingW-1:0] cfg_data
);
	import stp_pkg::*;

	logic [SpacingW-1:0] spacing_q;
	logic [CountW-1:0]   count_q;
	logic                valid_s1;
	in_item_t            item_s1;
	logic                room;
	logic                fire;
	out_item_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RST;
			count_q   <= COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SLOT_SPACING: spacing_q <= cfg_data;
				REG_SLOT_COUNT:   count_q   <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	stp_mode_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (item_s1),
		.slot_spacing (spacing_q),
		.slot_count   (count_q),
		.res          (res)
	);

	stp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// input side stalls only behind a held result beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a held result");

	a_zero_manual: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.zero_position) |->
		(out_item.mode_now == MODE_MANUAL && !out_item.motor_on))
		else $error("position reset outside homing exit");

	a_moving_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.mode_now == MODE_MOVING) |-> out_item.motor_on)
		else $error("motor stopped while moving");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("result beat lost");

endmodule

`default_nettype wire
